@@ hdl/kld_pkg.sv @@
// ---------------------------------------------------------------------------
// kld_pkg
// Shared types and constants of the divergence accumulator.
// ---------------------------------------------------------------------------
package kld_pkg;

    localparam int unsigned VAL_W   = 40;
    localparam int unsigned FLOOR_W = 25;
    localparam int unsigned TOT_W   = 64;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Fraction bits of the value format. No logic reads this constant,
    // so it only changes how the fields are read, never the bits.
    localparam int unsigned FRACTION_BITS = 24;

    localparam logic [0:0] REG_VALUE_FLOOR = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture clamped operands, start with x
        logic norm;      // normalize the current operand
        logic sq;        // one squaring round of the log unit
        logic save_gx;   // keep G(x), switch to y
        logic diff;      // form L = G(x) - G(y)
        logic mul_lo;    // first partial product of |L|*ln2
        logic mul_hi;    // second partial product
        logic tmul_lo;   // x * lnm, low half of lnm
        logic tmul_hi;   // x * lnm, high half of lnm
        logic accum;     // add the term to the total
        logic emit;      // capture the result and clear the total
    } t_kld_cmd;

endpackage

@@ hdl/kld_if.sv @@
// ---------------------------------------------------------------------------
// kld_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
interface kld_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/kld_datapath.sv @@
// ---------------------------------------------------------------------------
// kld_datapath
// Operand clamp, squaring log unit, partial-product multiplier, accumulator.
// ---------------------------------------------------------------------------
module kld_datapath (
    input  logic                    i_clk,
    input  kld_pkg::t_kld_cmd       i_cmd,
    input  logic [kld_pkg::VAL_W-1:0]   i_x,
    input  logic [kld_pkg::VAL_W-1:0]   i_y,
    input  logic [kld_pkg::FLOOR_W-1:0] i_floor,
    input  logic                    i_clr,
    output logic [kld_pkg::TOT_W-1:0]   o_total,
    output logic                    o_sat
);
    import kld_pkg::*;

    logic [VAL_W-1:0] r_x, r_y, r_v;
    logic [31:0]      r_m;
    logic [31:0]      r_frac;
    logic [5:0]       r_p;
    logic [37:0]      r_gx;
    logic             r_neg;
    logic [37:0]      r_lmag;
    logic [71:0]      r_acc;
    logic [63:0]      r_lnm;
    logic [63:0]      r_t;
    logic [63:0]      r_tot;
    logic             r_sat;

    logic [VAL_W-1:0] floor_v, cx, cy;
    logic [5:0]       lead;
    logic [63:0]      sqr;
    logic [37:0]      gcur;
    logic [64:0]      dsum;
    logic [63:0]      du;
    logic [64:0]      tsum;

    always_comb begin
        floor_v = (i_floor == '0) ? VAL_W'(1) : VAL_W'(i_floor);
        cx = (i_x < floor_v) ? floor_v : i_x;
        cy = (i_y < floor_v) ? floor_v : i_y;
        lead = '0;
        for (int i = 1; i < VAL_W; i++) begin
            if (r_v[i]) lead = 6'(i);
        end
        sqr  = 64'(r_m) * 64'(r_m);
        gcur = {r_p, r_frac};
        // d = +/-t - x + y, clamped at zero
        if (r_neg) dsum = 65'(r_y) - 65'(r_t) - 65'(r_x);
        else       dsum = 65'(r_t) + 65'(r_y) - 65'(r_x);
        du   = dsum[64] ? '0 : dsum[63:0];
        tsum = 65'(r_tot) + 65'(du);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= cx;
            r_y <= cy;
            r_v <= cx;
        end
        if (i_cmd.norm) begin
            r_p    <= lead;
            r_frac <= '0;
            if (lead <= 6'd31) r_m <= 32'(r_v << (6'd31 - lead));
            else               r_m <= 32'(r_v >> (lead - 6'd31));
        end
        if (i_cmd.sq) begin
            // The squared mantissa reaching 2.0 yields a one bit and a halving.
            if (sqr[63]) begin
                r_m    <= sqr[63:32];
                r_frac <= {r_frac[30:0], 1'b1};
            end else begin
                r_m    <= sqr[62:31];
                r_frac <= {r_frac[30:0], 1'b0};
            end
        end
        if (i_cmd.save_gx) begin
            r_gx <= gcur;
            r_v  <= r_y;
        end
        if (i_cmd.diff) begin
            r_neg  <= (gcur > r_gx);
            r_lmag <= (gcur > r_gx) ? (gcur - r_gx) : (r_gx - gcur);
        end
        if (i_cmd.mul_lo) r_acc <= 72'(64'(r_lmag[31:0]) * 64'(LN2_Q32));
        if (i_cmd.mul_hi) r_lnm <= 64'(r_lmag[37:32]) * 64'(LN2_Q32)
                                   + 64'(r_acc[63:32]);
        if (i_cmd.tmul_lo) r_acc <= 72'(r_x) * 72'(r_lnm[31:0]);
        if (i_cmd.tmul_hi) r_t <= 64'(r_x) * 64'(r_lnm[37:32]) + 64'(r_acc[71:32]);
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_tot <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.accum) begin
            if (tsum[64]) begin
                r_tot <= '1;
                r_sat <= 1'b1;
            end else begin
                r_tot <= tsum[63:0];
            end
        end else if (i_cmd.emit) begin
            r_tot <= '0;
            r_sat <= 1'b0;
        end
    end

    assign o_total = r_tot;
    assign o_sat   = r_sat;
endmodule

@@ hdl/kld_ctrl.sv @@
// ---------------------------------------------------------------------------
// kld_ctrl
// Sequencer for the per-item log, multiply and accumulate steps.
// ---------------------------------------------------------------------------
module kld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_busy,
    output logic              o_in_ready,
    output logic              o_emit,
    output kld_pkg::t_kld_cmd o_cmd
);
    import kld_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_NORM = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_DIFF = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_TMUL = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_second, n_second;
    logic       r_last, n_last;
    logic       r_half, n_half;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_second = r_second;
        n_last = r_last; n_half = r_half;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last = i_in_last; n_second = 1'b0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm = 1'b1; n_cnt = '0; n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    if (!r_second) begin
                        n_state = S_DIFF;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                if (!r_second) begin
                    o_cmd.save_gx = 1'b1; n_second = 1'b1; n_state = S_NORM;
                end else begin
                    o_cmd.diff = 1'b1; n_half = 1'b0; n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_lo = !r_half; o_cmd.mul_hi = r_half;
                n_half = !r_half;
                if (r_half) n_state = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.tmul_lo = !r_half; o_cmd.tmul_hi = r_half;
                n_half = !r_half;
                if (r_half) n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_emit = 1'b1; o_cmd.emit = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_second <= 1'b0;
            r_last <= 1'b0; r_half <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_second <= n_second;
            r_last <= n_last; r_half <= n_half;
        end
    end
endmodule

@@ hdl/kl_divergence_accumulator.sv @@
// ---------------------------------------------------------------------------
// kl_divergence_accumulator
// Streaming generalized KL divergence over pairs of Q16.24 values.
// ---------------------------------------------------------------------------
// Usage: each input item carries an observed value x, a model value y and
// a last flag. Both values are raised to the value_floor register, then
// x*ln(x/y) - x + y is added to a saturating 64-bit total. On the item
// flagged last, one result item carries the total and an overflow flag,
// and the total clears.
// Sequence: an item runs normalization and a 32-round squaring pass
// of the shared log unit for x, the same for y, four partial-product
// steps of the multiplier and the accumulate, plus the emit step when
// it closes a set; the squaring passes dominate. The block handles one
// item at a time. The result is registered in the emit step after the
// last item's accumulate and sits in an output register; a stalled
// receiver holds the block in its emit step until the register frees,
// and a new item is accepted as soon as the result is registered.
// Reset (synchronous, active low) clears the total, the flag, the output
// valid and sets value_floor to one LSB. Writes go through the APB port
// at address 0, only while the block is idle: a user rule, not enforced.
// ---------------------------------------------------------------------------
module kl_divergence_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kld_if.sink         in_ch,
    kld_if.source       out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kld_pkg::*;

    logic [FLOOR_W-1:0] r_floor;
    logic               wr;
    t_kld_cmd           cmd;
    logic               emit;
    logic [TOT_W-1:0]   total;
    logic               sat;
    logic               r_ov;
    logic [TOT_W-1:0]   r_otot;
    logic               r_osat;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr[1:0] == {REG_VALUE_FLOOR, 1'b0}) ? 32'(r_floor) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_W'(1);
        end else if (wr && paddr[1:0] == {REG_VALUE_FLOOR, 1'b0}) begin
            r_floor <= pwdata[FLOOR_W-1:0];
        end
    end

    kld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_last  (in_ch.data[0]),
        .i_out_busy (r_ov && !out_ch.ready),
        .o_in_ready (in_ch.ready),
        .o_emit     (emit),
        .o_cmd      (cmd)
    );

    kld_datapath u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_x     (in_ch.data[80:41]),
        .i_y     (in_ch.data[40:1]),
        .i_floor (r_floor),
        .i_clr   (!i_rst_n),
        .o_total (total),
        .o_sat   (sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (out_ch.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_otot <= total;
            r_osat <= sat;
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = {r_otot, r_osat};

`ifndef SYNTHESIS
    // A result is only registered when the output slot is free or draining.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_ov || out_ch.ready))
        else $error("result register overwritten");
    // No item is taken while a result waits in the emit step.
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !$past(in_ch.ready))
        else $error("item accepted during emit");
    // After an emit the running total starts from zero.
    a_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (total == '0 && !sat))
        else $error("total not cleared");
`endif
endmodule
